// File: hw/rtl/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants for the timed slot allocator: field widths,
// register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tsa_pkg;

  localparam int TIME_W    = 32;
  localparam int LIFE_W    = 24;
  localparam int CFG_W     = 6;
  localparam int SLOT_IDX_W = 5;

  // Register indexes on the configuration port
  localparam logic REG_SLOT_COUNT      = 1'b0;
  localparam logic REG_OVERFLOW_POLICY = 1'b1;

  // Overflow policy codes
  localparam logic POLICY_DROP_NEWEST   = 1'b0;
  localparam logic POLICY_REPLACE_OLDEST = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OLDEST,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture request, start expiry scan at the pointer
    logic scan;       // expiry scan phase active
    logic take_hit;   // grant the slot under check
    logic take_drop;  // refuse the request
    logic old_init;   // restart reads at slot zero for the oldest search
    logic old;        // oldest search phase active
    logic take_old;   // grant the oldest slot as an eviction
    logic commit;     // write the slot and load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // checked slot is free or expired
    logic chk_end;    // checked slot is the last one of the pass
    logic policy;     // overflow policy register
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

// File: hw/rtl/tsa_ram.sv
// ----------------------------------------------------------------------------
// tsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Sequencer for one request: expiry scan, optional oldest search, then
// commit of the result into the slot store and the output register.
// ----------------------------------------------------------------------------
module tsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsa_pkg::status_t status,
  output tsa_pkg::cmd_t    cmd,
  output tsa_pkg::state_t  state
);

  import tsa_pkg::*;

  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_FINISH;
        end else if (status.chk_end) begin
          if (status.policy == POLICY_REPLACE_OLDEST) begin
            cmd.old_init = 1'b1;
            state_next   = ST_OLDEST;
          end else begin
            cmd.take_drop = 1'b1;
            state_next    = ST_FINISH;
          end
        end
      end
      ST_OLDEST: begin
        cmd.old = 1'b1;
        if (status.chk_end) begin
          cmd.take_old = 1'b1;
          state_next   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/tsa_datapath.sv
// ----------------------------------------------------------------------------
// tsa_datapath
// Configuration registers, slot store with per-slot valid bits, read
// address sequencing, expiry and oldest checks, and the output register.
// ----------------------------------------------------------------------------
module tsa_datapath #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [tsa_pkg::CFG_W-1:0]        cfg_data,
  input  logic [tsa_pkg::TIME_W-1:0]       current_time,
  input  logic [tsa_pkg::LIFE_W-1:0]       lifetime,
  input  tsa_pkg::cmd_t                    cmd,
  output tsa_pkg::status_t                 status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             granted,
  output logic [tsa_pkg::SLOT_IDX_W-1:0]   slot_index,
  output logic                             evicted
);

  import tsa_pkg::*;

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = (CFG_W + 1 > CW) ? CFG_W + 1 : CW;
  localparam int DW = TIME_W + LIFE_W;

  // Configuration
  logic [CFG_W-1:0] slot_count;
  logic             policy;
  logic [SW-1:0]    count_wide;
  logic [CW-1:0]    n_eff;

  // Request and search state
  logic [TIME_W-1:0]  now_q;
  logic [LIFE_W-1:0]  life_q;
  logic [IW-1:0]      ptr;
  logic [IW-1:0]      addr;
  logic [CW-1:0]      cnt;
  logic               issue;
  logic [IW-1:0]      addr_inc;
  logic [MAX_SLOTS-1:0] vld;

  // Check stage
  logic               chk_vld;
  logic               chk_last;
  logic [IW-1:0]      chk_idx;
  logic               chk_bit;
  logic [DW-1:0]      rd_data;
  logic [TIME_W-1:0]  rd_start;
  logic [LIFE_W-1:0]  rd_life;
  logic [TIME_W:0]    rd_end;
  logic               expired;

  // Oldest search
  logic [TIME_W-1:0]  best_start;
  logic [IW-1:0]      best_idx;
  logic               best_first;
  logic               best_take;
  logic [IW-1:0]      best_idx_next;

  // Result under construction
  logic               res_grant;
  logic               res_evict;
  logic [IW-1:0]      pick;
  logic [IW-1:0]      pick_inc;

  // Clamp the slot count to 1..MAX_SLOTS
  always_comb begin
    count_wide = SW'(slot_count);
    if (count_wide == '0) begin
      n_eff = CW'(1);
    end else if (count_wide > SW'(MAX_SLOTS)) begin
      n_eff = CW'(MAX_SLOTS);
    end else begin
      n_eff = CW'(count_wide);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= CFG_W'(1);
      policy     <= POLICY_DROP_NEWEST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOT_COUNT:      slot_count <= cfg_data;
        REG_OVERFLOW_POLICY: policy     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Issue one read per cycle while a pass is running
  assign issue    = (cmd.scan || cmd.old) && (cnt < n_eff);
  assign addr_inc = (CW'(addr) + CW'(1) == n_eff) ? '0 : IW'(CW'(addr) + CW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= ptr;
      cnt  <= '0;
    end else if (cmd.old_init) begin
      addr <= '0;
      cnt  <= '0;
    end else if (issue) begin
      addr <= addr_inc;
      cnt  <= cnt + CW'(1);
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q  <= current_time;
      life_q <= lifetime;
    end
  end

  // Slot store
  tsa_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit && res_grant),
    .waddr (pick),
    .wdata ({now_q, life_q}),
    .raddr (addr),
    .rdata (rd_data)
  );

  // Per-slot valid bits: an invalid slot reads as free
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == REG_SLOT_COUNT)) begin
      vld <= '0;
    end else if (cmd.commit && res_grant) begin
      vld[pick] <= 1'b1;
    end
  end

  // Track the read in flight alongside the RAM latency
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else begin
      chk_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx  <= addr;
    chk_last <= (cnt == n_eff - CW'(1));
    chk_bit  <= vld[addr];
  end

  // Expiry check on the slot just read
  assign rd_start = chk_bit ? rd_data[DW-1:LIFE_W] : '0;
  assign rd_life  = rd_data[LIFE_W-1:0];
  assign rd_end   = {1'b0, rd_start} + (TIME_W+1)'(rd_life);
  assign expired  = (rd_start == '0) || ({1'b0, now_q} >= rd_end);

  assign status.hit      = chk_vld && expired;
  assign status.chk_end  = chk_vld && chk_last;
  assign status.policy   = policy;
  assign status.out_free = !out_valid || out_ready;

  // Oldest search: strict compare keeps the lowest index on ties
  assign best_take     = best_first || (rd_start < best_start);
  assign best_idx_next = best_take ? chk_idx : best_idx;

  always_ff @(posedge clk) begin
    if (cmd.old_init) begin
      best_first <= 1'b1;
    end else if (cmd.old && chk_vld) begin
      best_first <= 1'b0;
      if (best_take) begin
        best_start <= rd_start;
        best_idx   <= chk_idx;
      end
    end
  end

  // Latch the outcome of the search
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      res_grant <= 1'b1;
      res_evict <= 1'b0;
      pick      <= chk_idx;
    end else if (cmd.take_old) begin
      res_grant <= 1'b1;
      res_evict <= 1'b1;
      pick      <= best_idx_next;
    end else if (cmd.take_drop) begin
      res_grant <= 1'b0;
      res_evict <= 1'b0;
      pick      <= '0;
    end
  end

  // Advance the search pointer past a granted slot
  assign pick_inc = (CW'(pick) + CW'(1) == n_eff) ? '0 : IW'(CW'(pick) + CW'(1));

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == REG_SLOT_COUNT)) begin
      ptr <= '0;
    end else if (cmd.commit && res_grant) begin
      ptr <= pick_inc;
    end
  end

  // Output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted    <= res_grant;
      evicted    <= res_evict;
      slot_index <= SLOT_IDX_W'(pick);
    end
  end

endmodule

// File: hw/rtl/timed_slot_allocator.sv
// ----------------------------------------------------------------------------
// timed_slot_allocator
// Round-robin slot allocator with expiry and an optional replace-oldest
// policy when every slot is busy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request word: current_time
//   and lifetime. Output channel (out_valid/out_ready) returns one word per
//   request: granted, slot_index, evicted.
//   Configuration: cfg_we writes cfg_data to register cfg_index at the clock
//   edge (0 slot_count, 1 overflow_policy). Writing slot_count frees every
//   slot and resets the search pointer. Write only while the block is idle.
// Timing:
//   Requests are handled one at a time, one slot checked per cycle. A
//   request is granted at the first free or expired slot found; a dropped
//   one checks all N active slots, and one that runs the oldest search
//   checks all N and then reads all N again from slot zero. With the output
//   register free the result word appears in the same cycle that the next
//   request can be accepted. The slot store's single read port sets the rate.
// Reset and stalls:
//   rst (synchronous) frees all slots, sets slot_count to 1 and the drop
//   policy. The result sits in an output register; the next request is
//   accepted while it waits, and its commit holds until the register is free.
// ----------------------------------------------------------------------------
module timed_slot_allocator #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [tsa_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tsa_pkg::TIME_W-1:0]     current_time,
  input  logic [tsa_pkg::LIFE_W-1:0]     lifetime,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           granted,
  output logic [tsa_pkg::SLOT_IDX_W-1:0] slot_index,
  output logic                           evicted
);

  import tsa_pkg::*;

  cmd_t    cmd;
  status_t status;
  state_t  state;

  tsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  tsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .current_time (current_time),
    .lifetime     (lifetime),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .granted      (granted),
    .slot_index   (slot_index),
    .evicted      (evicted)
  );

  // A refused request reports no slot and no eviction
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (slot_index == '0 && !evicted))
    else $error("dropped request carries slot or eviction");

  // An accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while a request is in progress");

  // A new result word appears only from the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("output loaded outside the finish step");

  // An eviction is only reported from the oldest search
  a_evict_path: assert property (@(posedge clk) disable iff (rst)
    cmd.take_old |-> (state == ST_OLDEST && status.policy == POLICY_REPLACE_OLDEST))
    else $error("eviction taken outside replace-oldest search");

endmodule
